// ===== src/kplg_pkg.sv =====
`timescale 1ns / 1ps

package kplg_pkg;

	// Configuration register indexes
	localparam int          CFG_IDX_W      = 4;
	localparam int          CFG_DATA_W     = 5;
	localparam logic [3:0]  REG_SET_SIZE   = 4'd0;
	localparam logic [3:0]  REG_PICK_COUNT = 4'd1;

	localparam logic [4:0]  CFG_RESET      = 5'd4;
	localparam logic [4:0]  RUN_MAX        = 5'd16;

	// Commands passed from front to back
	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_NEXT    = 2'd0;
	localparam cmd_t CMD_EXHAUST = 2'd1;
	localparam cmd_t CMD_RESTART = 2'd2;

	// Settings seen by the back end
	typedef struct packed {
		logic [4:0] n;       // effective set size, saturated
		logic [4:0] k;       // pick count
		logic       reload;  // register write: rebuild state
	} cfg_t;

endpackage

// ===== src/k_permutation_lex_generator.sv =====
`timescale 1ns / 1ps

// Lexicographic k-permutation generator.
// Input queue side: restart with push/full; a transaction happens when push is
// high and full is low. restart=1 rewinds to the first arrangement and yields
// nothing; restart=0 asks for the next arrangement of k values out of 1..n.
// Result queue side: empty/pop. Each request yields k results (value,
// position, last_element on the final one), or a single result with
// exhausted=1 once the enumeration is done or when k is unusable.
// Config port: cfg_we/cfg_index/cfg_data; index 0 is set_size, 1 pick_count.
// A write to either register also rewinds the enumeration.
// Write only while the block is idle. The back end pops a queued request while
// idle, walks the choice stack one level per cycle (no walk for the first
// arrangement), then sends one element per cycle while the result register is
// free or being popped; a walk that runs out ends in an exhausted marker instead.
// The walk and the serial emission set the rate; the two-entry command queue
// lets requests be taken while results are still waiting.
// Reset: set_size and pick_count return to 4, the value array to 1..N_MAX,
// queues are emptied. No clearing pass is needed.
// A stalled receiver holds the result register; the back end waits and the
// command queue fills, after which full goes high.
module k_permutation_lex_generator #(
	parameter int N_MAX = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic                            restart,
	output logic                            empty,
	input  logic                            pop,
	output logic [4:0]                      element_value,
	output logic [3:0]                      element_position,
	output logic                            last_element,
	output logic                            exhausted,
	input  logic                            cfg_we,
	input  logic [kplg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [kplg_pkg::CFG_DATA_W-1:0] cfg_data
);

	kplg_pkg::cfg_t cfg;
	kplg_pkg::cmd_t wr_cmd;
	kplg_pkg::cmd_t rd_cmd;
	logic           q_push;
	logic           q_pop;
	logic           q_empty;

	// front: config registers and request classification
	kplg_front #(
		.N_MAX (N_MAX)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.restart   (restart),
		.q_full    (full),
		.q_push    (q_push),
		.q_cmd     (wr_cmd),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// decouples request intake from the enumeration engine
	kplg_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_push),
		.wr_cmd (wr_cmd),
		.full   (full),
		.rd     (q_pop),
		.rd_cmd (rd_cmd),
		.empty  (q_empty)
	);

	// back: choice stack walk, array rotation, serial emission
	kplg_back #(
		.N_MAX (N_MAX)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg),
		.q_empty          (q_empty),
		.q_cmd            (rd_cmd),
		.q_pop            (q_pop),
		.empty            (empty),
		.pop              (pop),
		.element_value    (element_value),
		.element_position (element_position),
		.last_element     (last_element),
		.exhausted        (exhausted)
	);

endmodule

// ===== src/kplg_front.sv =====
`timescale 1ns / 1ps

module kplg_front #(
	parameter int N_MAX = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic                           restart,
	input  logic                           q_full,
	output logic                           q_push,
	output kplg_pkg::cmd_t                 q_cmd,
	input  logic                           cfg_we,
	input  logic [kplg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [kplg_pkg::CFG_DATA_W-1:0] cfg_data,
	output kplg_pkg::cfg_t                 cfg
);

	logic [4:0] set_size_q;
	logic [4:0] pick_count_q;
	logic [4:0] n_eff;
	logic       k_bad;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_size_q   <= kplg_pkg::CFG_RESET;
			pick_count_q <= kplg_pkg::CFG_RESET;
		end else if (cfg_we) begin
			if (cfg_index == kplg_pkg::REG_SET_SIZE) begin
				set_size_q <= cfg_data;
			end
			if (cfg_index == kplg_pkg::REG_PICK_COUNT) begin
				pick_count_q <= cfg_data;
			end
		end
	end

	// saturate n at the array depth
	assign n_eff = (int'(set_size_q) > N_MAX) ? 5'(N_MAX) : set_size_q;

	assign k_bad = (pick_count_q == 5'd0) || (pick_count_q > n_eff)
		|| (pick_count_q > kplg_pkg::RUN_MAX);

	assign q_push = push && !q_full;

	always_comb begin
		if (restart) begin
			q_cmd = kplg_pkg::CMD_RESTART;
		end else if (k_bad) begin
			q_cmd = kplg_pkg::CMD_EXHAUST;
		end else begin
			q_cmd = kplg_pkg::CMD_NEXT;
		end
	end

	assign cfg.n      = n_eff;
	assign cfg.k      = pick_count_q;
	assign cfg.reload = cfg_we && ((cfg_index == kplg_pkg::REG_SET_SIZE)
		|| (cfg_index == kplg_pkg::REG_PICK_COUNT));

endmodule

// ===== src/kplg_cmd_fifo.sv =====
`timescale 1ns / 1ps

module kplg_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  kplg_pkg::cmd_t wr_cmd,
	output logic           full,
	input  logic           rd,
	output kplg_pkg::cmd_t rd_cmd,
	output logic           empty
);

	kplg_pkg::cmd_t mem_q [2];
	logic           wp_q;
	logic           rp_q;
	logic [1:0]     cnt_q;

	assign full   = (cnt_q == 2'd2);
	assign empty  = (cnt_q == 2'd0);
	assign rd_cmd = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) begin
				wp_q <= ~wp_q;
			end
			if (rd) begin
				rp_q <= ~rp_q;
			end
			case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== src/kplg_back.sv =====
`timescale 1ns / 1ps

module kplg_back #(
	parameter int N_MAX = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  kplg_pkg::cfg_t cfg,
	input  logic           q_empty,
	input  kplg_pkg::cmd_t q_cmd,
	output logic           q_pop,
	output logic           empty,
	input  logic           pop,
	output logic [4:0]     element_value,
	output logic [3:0]     element_position,
	output logic           last_element,
	output logic           exhausted
);

	localparam int CW = $clog2(N_MAX);
	localparam int VW = $clog2(N_MAX + 1);
	localparam int XW = CW + 6;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;
	localparam logic [1:0] ST_EXH  = 2'd3;

	logic [1:0]    state_q;
	logic [VW-1:0] v_q   [N_MAX];
	logic [CW-1:0] stk_q [N_MAX];
	logic [VW-1:0] v_up  [N_MAX];
	logic [CW-1:0] lv_q;
	logic [3:0]    pos_q;
	logic          fin_q;
	logic          started_q;

	logic          ovalid_q;
	logic [4:0]    oval_q;
	logic [3:0]    opos_q;
	logic          olast_q;
	logic          oexh_q;

	logic [XW-1:0] lv_x, c_raw_x, c_x, c1_x, n_x;
	logic [CW-1:0] c1_idx, pos_idx, k_m1_idx;
	logic [CW+3:0] pos_wide;
	logic [CW+4:0] k_m1_wide;
	logic [VW-1:0] v_lv, v_c1, v_pos;
	logic [3:0]    k_last;
	logic          adv_ok;
	logic          out_free;

	// one level of the choice walk
	assign lv_x    = XW'(lv_q);
	assign n_x     = XW'(cfg.n);
	assign c_raw_x = XW'(stk_q[lv_q]);
	assign c_x     = ((c_raw_x >= n_x) || (c_raw_x < lv_x)) ? lv_x : c_raw_x;
	assign c1_x    = c_x + XW'(1);
	assign adv_ok  = (c1_x < n_x);
	assign c1_idx  = c1_x[CW-1:0];
	assign v_lv    = v_q[lv_q];
	assign v_c1    = v_q[c1_idx];

	assign pos_wide  = {{CW{1'b0}}, pos_q};
	assign pos_idx   = pos_wide[CW-1:0];
	assign v_pos     = v_q[pos_idx];
	assign k_m1_wide = {{CW{1'b0}}, cfg.k - 5'd1};
	assign k_m1_idx  = k_m1_wide[CW-1:0];
	assign k_last    = 4'(cfg.k - 5'd1);

	always_comb begin
		for (int i = 0; i < N_MAX; i++) begin
			v_up[i] = v_q[(i + 1) % N_MAX];
		end
	end

	assign out_free = !ovalid_q || pop;
	assign q_pop    = (state_q == ST_IDLE) && !q_empty && !cfg.reload;

	// value array and choice stack
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N_MAX; i++) begin
				v_q[i]   <= VW'(i + 1);
				stk_q[i] <= CW'(i);
			end
		end else if (cfg.reload || (q_pop && (q_cmd == kplg_pkg::CMD_RESTART))) begin
			for (int i = 0; i < N_MAX; i++) begin
				v_q[i]   <= VW'(i + 1);
				stk_q[i] <= CW'(i);
			end
		end else if (state_q == ST_WALK) begin
			if (adv_ok) begin
				// rotate back then rotate in one further: a plain swap
				v_q[lv_q]   <= v_c1;
				v_q[c1_idx] <= v_lv;
				for (int i = 0; i < N_MAX; i++) begin
					if (XW'(i) > lv_x) begin
						stk_q[i] <= CW'(i);
					end
				end
				stk_q[lv_q] <= c1_x[CW-1:0];
			end else begin
				for (int i = 0; i < N_MAX; i++) begin
					if ((XW'(i) >= lv_x) && (XW'(i) < c_x)) begin
						v_q[i] <= v_up[i];
					end
				end
				v_q[c_x[CW-1:0]] <= v_lv;
				stk_q[lv_q]      <= lv_q;
			end
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			lv_q      <= '0;
			pos_q     <= 4'd0;
			fin_q     <= 1'b0;
			started_q <= 1'b0;
		end else if (cfg.reload) begin
			state_q   <= ST_IDLE;
			fin_q     <= 1'b0;
			started_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						case (q_cmd)
							kplg_pkg::CMD_RESTART: begin
								fin_q     <= 1'b0;
								started_q <= 1'b0;
							end
							kplg_pkg::CMD_EXHAUST: begin
								state_q <= ST_EXH;
							end
							default: begin
								if (fin_q) begin
									state_q <= ST_EXH;
								end else if (!started_q) begin
									started_q <= 1'b1;
									pos_q     <= 4'd0;
									state_q   <= ST_EMIT;
								end else begin
									lv_q    <= k_m1_idx;
									state_q <= ST_WALK;
								end
							end
						endcase
					end
				end
				ST_WALK: begin
					if (adv_ok) begin
						pos_q   <= 4'd0;
						state_q <= ST_EMIT;
					end else if (lv_q == '0) begin
						state_q <= ST_EXH;
					end else begin
						lv_q <= lv_q - CW'(1);
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						pos_q <= pos_q + 4'd1;
						if (pos_q == k_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_EXH: begin
					if (out_free) begin
						fin_q   <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if ((state_q == ST_EMIT || state_q == ST_EXH) && out_free) begin
			ovalid_q <= 1'b1;
		end else if (pop) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			oval_q  <= 5'(v_pos);
			opos_q  <= pos_q;
			olast_q <= (pos_q == k_last);
			oexh_q  <= 1'b0;
		end else if (state_q == ST_EXH && out_free) begin
			oval_q  <= 5'd0;
			opos_q  <= 4'd0;
			olast_q <= 1'b1;
			oexh_q  <= 1'b1;
		end
	end

	assign empty            = !ovalid_q;
	assign element_value    = oval_q;
	assign element_position = opos_q;
	assign last_element     = olast_q;
	assign exhausted        = oexh_q;

endmodule

// ===== src/kplg_checker.sv =====
`timescale 1ns / 1ps

module kplg_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [4:0] element_value,
	input logic [3:0] element_position,
	input logic       last_element,
	input logic       exhausted
);

	// exhausted result carries fixed fields
	a_exh_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && exhausted) |->
		(element_value == 5'd0 && element_position == 4'd0 && last_element))
		else $error("exhausted result with bad fields");

	a_value_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !exhausted) |-> (element_value != 5'd0))
		else $error("arrangement element with value zero");

	// positions within a run count up by one
	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && !last_element && !exhausted) |=>
		(empty || (element_position == 4'($past(element_position) + 4'd1))))
		else $error("position does not follow previous element");

	a_run_start: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && last_element) |=> (empty || element_position == 4'd0))
		else $error("new run does not start at position zero");

endmodule

bind k_permutation_lex_generator kplg_checker u_kplg_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.empty            (empty),
	.pop              (pop),
	.element_value    (element_value),
	.element_position (element_position),
	.last_element     (last_element),
	.exhausted        (exhausted)
);
